[hw/rtl/lsdrs_pkg.sv]
// Shared types and constants for the decimal LSD radix sort block.
// Used by the divide-by-ten unit, the bucket counter, the top level and the checker.
// Depends on nothing.
`timescale 1ns / 1ps

package lsdrs_pkg;

  localparam int VALUE_W     = 31;
  localparam int DIGIT_W     = 4;
  localparam int PASS_W      = 4;
  localparam int POS_W       = 6;
  localparam int STEP_W      = 4;
  localparam int RADIX       = 10;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  // Reciprocal of ten for a 32-bit dividend: q / 10 == (q * MAGIC) >> 35.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // Request kinds carried in bit 0 of the input tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PASS = 1'b1;

  typedef enum logic [1:0] {
    BKT_NOP   = 2'd0,
    BKT_CLEAR = 2'd1,
    BKT_INCR  = 2'd2,
    BKT_PFX   = 2'd3
  } bkt_op_t;

  typedef struct packed {
    bkt_op_t                   op;
    logic [DIGIT_W-1:0]        digit;
    logic [STEP_W-1:0]         pfx_idx;
  } bkt_ctl_t;

endpackage

[hw/rtl/lsdrs_div10.sv]
// Two-stage divide-by-ten unit: multiply by the reciprocal, then form the remainder.
// Shared by every digit step of a load. Depends on lsdrs_pkg.
`timescale 1ns / 1ps

module lsdrs_div10 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lsdrs_pkg::VALUE_W-1:0] dividend,
  output logic                          done,
  output logic [lsdrs_pkg::VALUE_W-1:0] quot,
  output logic [lsdrs_pkg::DIGIT_W-1:0] rem
);
  import lsdrs_pkg::*;

  localparam int PROD_W = VALUE_W + 32;
  localparam int QUOT_W = PROD_W - DIV10_SHIFT;

  logic [PROD_W-1:0]  prod_r;
  logic [VALUE_W-1:0] d_r;
  logic               s1_r;
  logic               done_r;
  logic [VALUE_W-1:0] quot_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [QUOT_W-1:0]  quot_c;
  logic [VALUE_W-1:0] tenx_c;
  logic [VALUE_W-1:0] diff_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      done_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(dividend) * PROD_W'(DIV10_MAGIC);
    d_r    <= dividend;
    quot_r <= VALUE_W'(quot_c);
    rem_r  <= diff_c[DIGIT_W-1:0];
  end

  always_comb begin
    quot_c = prod_r[PROD_W-1:DIV10_SHIFT];
    tenx_c = VALUE_W'({quot_c, 3'b000}) + VALUE_W'({quot_c, 1'b0});
    diff_c = d_r - tenx_c;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

[hw/rtl/lsdrs_buckets.sv]
// Ten bucket counters that count digits, turn into running offsets by a prefix
// walk, and then hand out scatter slots. Depends on lsdrs_pkg.
`timescale 1ns / 1ps

module lsdrs_buckets #(
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  lsdrs_pkg::bkt_ctl_t ctl,
  output logic [CNT_W-1:0]    off_rd
);
  import lsdrs_pkg::*;

  logic [CNT_W-1:0] off_r [RADIX];
  logic [CNT_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      BKT_CLEAR: begin
        for (int k = 0; k < RADIX; k++) begin
          off_r[k] <= '0;
        end
        sum_r <= '0;
      end
      BKT_INCR: begin
        off_r[ctl.digit] <= off_r[ctl.digit] + CNT_W'(1);
      end
      BKT_PFX: begin
        off_r[ctl.pfx_idx] <= sum_r;
        sum_r              <= sum_r + off_r[ctl.pfx_idx];
      end
      default: begin
      end
    endcase
  end

  assign off_rd = off_r[ctl.digit];

endmodule

[hw/rtl/lsd_decimal_radix_sort_unit.sv]
// Load: the shared divide-by-ten unit produces the digits of the value one after another.
// Pass: the accepted request, the count walk, the prefix walk, the scatter walk, then each
// emitted item through the memories; output stalls add to the pass.
// One request is taken at a time; in_tready is high only while the sequencer is idle.
// rst_n is synchronous and active low: it empties the set, sets the digit-count maximum
// to one and the pass index to zero. The value, digit and order memories are not cleared.
`timescale 1ns / 1ps

module lsd_decimal_radix_sort_unit #(
  parameter int MAX_ITEMS  = 64,
  parameter int MAX_DIGITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: value [30:0], then one zero pad bit.
  input  logic [lsdrs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: op [0], start_set [1].
  input  logic [lsdrs_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: sorted_value [30:0], position [36:31], pass_number [40:37], zero pad.
  output logic [lsdrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import lsdrs_pkg::*;

  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DIG_W     = DIGIT_W * MAX_DIGITS;
  localparam int POS_EXT_W = POS_W + IDX_W;
  localparam int PAD_W     = OUT_TDATA_W - VALUE_W - POS_W - PASS_W;

  localparam logic [CNT_W-1:0]  CAP       = CNT_W'(MAX_ITEMS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_DIGITS - 1);
  localparam logic [STEP_W-1:0] LAST_PFX  = STEP_W'(RADIX - 1);

  // Sequencer. A load runs the divide loop and writes the digit row; a pass runs the
  // count walk, the prefix walk, the scatter walk and then the emit loop.
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DIV  = 10'b00_0000_0010,
    S_DWR  = 10'b00_0000_0100,
    S_CNT  = 10'b00_0000_1000,
    S_PFX  = 10'b00_0001_0000,
    S_SCT  = 10'b00_0010_0000,
    S_ERD  = 10'b00_0100_0000,
    S_EIX  = 10'b00_1000_0000,
    S_ELD  = 10'b01_0000_0000,
    S_EOUT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   n_r;
  logic [PASS_W-1:0]  maxdc_r;
  logic [PASS_W-1:0]  pass_r;
  logic [CNT_W-1:0]   i_r;
  logic [STEP_W-1:0]  step_r;
  logic [VALUE_W-1:0] q_r;
  logic [PASS_W-1:0]  dc_r;
  logic [DIG_W-1:0]   dv_r;
  logic [IDX_W-1:0]   wa_r;
  logic               v1_r;
  logic               v2_r;

  // Memories with registered reads.
  logic [VALUE_W-1:0] val_mem [MAX_ITEMS];
  logic [DIG_W-1:0]   dig_mem [MAX_ITEMS];
  logic [IDX_W-1:0]   oc_mem  [MAX_ITEMS];
  logic [IDX_W-1:0]   on_mem  [MAX_ITEMS];
  logic [VALUE_W-1:0] val_q_r;
  logic [DIG_W-1:0]   dig_q_r;
  logic [IDX_W-1:0]   oc_q_r;
  logic [IDX_W-1:0]   on_q_r;
  logic [IDX_W-1:0]   idx2_r;

  logic [VALUE_W-1:0] out_val_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [PASS_W-1:0]  out_pass_r;
  logic               out_last_r;
  logic               out_valid_r;

  logic               in_op;
  logic               in_start;
  logic [VALUE_W-1:0] in_value;
  logic               in_acc;
  logic [CNT_W-1:0]   n_eff;
  logic               room;
  logic               load_acc;
  logic               store;
  logic               pass_go;
  logic               walking;
  logic               issue;
  logic               walk_end;
  logic               div_start;
  logic [VALUE_W-1:0] div_in;
  logic               div_done;
  logic [VALUE_W-1:0] div_quot;
  logic [DIGIT_W-1:0] div_rem;
  logic [DIGIT_W-1:0] cur_digit;
  bkt_ctl_t           bkt_ctl;
  logic [CNT_W-1:0]   bkt_off;
  logic               oc_we;
  logic [IDX_W-1:0]   oc_wa;
  logic [IDX_W-1:0]   oc_wd;
  logic [POS_EXT_W-1:0] pos_ext;

  // Request decode.
  assign in_op    = in_tuser[0];
  assign in_start = in_tuser[1];
  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  // A new set starts from slot zero; a full store drops the value.
  assign n_eff    = in_start ? '0 : n_r;
  assign room     = (n_eff < CAP);
  assign load_acc = in_acc && (in_op == OP_LOAD);
  assign store    = load_acc && room;
  assign pass_go  = in_acc && (in_op == OP_PASS) && (n_r != '0) && (pass_r < maxdc_r);

  // Both walks issue one order-memory read per cycle; two valid bits follow the
  // order read and the digit read down the pipe.
  assign walking  = (state_r == S_CNT) || (state_r == S_SCT);
  assign issue    = walking && (i_r < n_r);
  assign walk_end = (i_r == n_r) && !v1_r && !v2_r;

  // The divide unit is fed the loaded value first, then each quotient in turn.
  assign div_start = store || ((state_r == S_DIV) && div_done && (step_r != LAST_STEP));
  assign div_in    = (state_r == S_IDLE) ? in_value : div_quot;

  lsdrs_div10 u_div10 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Digit of the current pass from the stored digit row.
  always_comb begin
    cur_digit = '0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (PASS_W'(k) == pass_r) begin
        cur_digit = dig_q_r[k*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bkt_ctl.op      = BKT_NOP;
    bkt_ctl.digit   = cur_digit;
    bkt_ctl.pfx_idx = step_r;
    if (pass_go) begin
      bkt_ctl.op = BKT_CLEAR;
    end else if (walking && v2_r) begin
      bkt_ctl.op = BKT_INCR;
    end else if (state_r == S_PFX) begin
      bkt_ctl.op = BKT_PFX;
    end
  end

  lsdrs_buckets #(
    .CNT_W (CNT_W)
  ) u_buckets (
    .clk    (clk),
    .ctl    (bkt_ctl),
    .off_rd (bkt_off)
  );

  // The current order is written by a load (append) and by the emit loop (copy back).
  assign oc_we = store || (state_r == S_EIX);
  assign oc_wa = store ? n_eff[IDX_W-1:0] : i_r[IDX_W-1:0];
  assign oc_wd = store ? n_eff[IDX_W-1:0] : on_q_r;

  always_ff @(posedge clk) begin
    if (store) begin
      val_mem[n_eff[IDX_W-1:0]] <= in_value;
    end
    val_q_r <= val_mem[on_q_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DWR) begin
      dig_mem[wa_r] <= dv_r;
    end
    dig_q_r <= dig_mem[oc_q_r];
  end

  always_ff @(posedge clk) begin
    if (oc_we) begin
      oc_mem[oc_wa] <= oc_wd;
    end
    oc_q_r <= oc_mem[i_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_SCT) && v2_r) begin
      on_mem[bkt_off[IDX_W-1:0]] <= idx2_r;
    end
    on_q_r <= on_mem[i_r[IDX_W-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (store) begin
          state_nxt = S_DIV;
        end else if (pass_go) begin
          state_nxt = S_CNT;
        end
      end
      S_DIV: begin
        if (div_done && (step_r == LAST_STEP)) begin
          state_nxt = S_DWR;
        end
      end
      S_DWR: state_nxt = S_IDLE;
      S_CNT: begin
        if (walk_end) begin
          state_nxt = S_PFX;
        end
      end
      S_PFX: begin
        if (step_r == LAST_PFX) begin
          state_nxt = S_SCT;
        end
      end
      S_SCT: begin
        if (walk_end) begin
          state_nxt = S_ERD;
        end
      end
      S_ERD: state_nxt = S_EIX;
      S_EIX: state_nxt = S_ELD;
      S_ELD: state_nxt = S_EOUT;
      S_EOUT: begin
        if (out_tready) begin
          state_nxt = out_last_r ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      maxdc_r     <= PASS_W'(1);
      pass_r      <= '0;
      i_r         <= '0;
      step_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;

      if (load_acc) begin
        // A new set always has room, so the store below also restarts the count
        // and the pass index; the start bit only has to reset the maximum here.
        if (in_start) begin
          maxdc_r <= PASS_W'(1);
        end
        if (room) begin
          n_r    <= n_eff + CNT_W'(1);
          pass_r <= '0;
          step_r <= '0;
        end
      end

      if ((state_r == S_DIV) && div_done) begin
        step_r <= step_r + STEP_W'(1);
      end

      if ((state_r == S_DWR) && (dc_r > maxdc_r)) begin
        maxdc_r <= dc_r;
      end

      if (pass_go) begin
        i_r <= '0;
      end else if (issue) begin
        i_r <= i_r + CNT_W'(1);
      end

      if ((state_r == S_CNT) && walk_end) begin
        step_r <= '0;
      end

      if (state_r == S_PFX) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == LAST_PFX) begin
          i_r <= '0;
        end
      end

      if ((state_r == S_SCT) && walk_end) begin
        i_r <= '0;
      end

      if (state_r == S_ELD) begin
        out_valid_r <= 1'b1;
      end

      if ((state_r == S_EOUT) && out_tready) begin
        out_valid_r <= 1'b0;
        if (out_last_r) begin
          pass_r <= pass_r + PASS_W'(1);
        end else begin
          i_r <= i_r + CNT_W'(1);
        end
      end
    end
  end

  assign pos_ext = POS_EXT_W'(i_r[IDX_W-1:0]);

  // Payload registers. The digit count is the number of nonzero dividends seen,
  // which saturates at MAX_DIGITS because the loop stops there.
  always_ff @(posedge clk) begin
    if (store) begin
      q_r  <= in_value;
      dc_r <= '0;
      wa_r <= n_eff[IDX_W-1:0];
    end
    if ((state_r == S_DIV) && div_done) begin
      dv_r <= (dv_r >> DIGIT_W) | (DIG_W'(div_rem) << (DIG_W - DIGIT_W));
      q_r  <= div_quot;
      if (q_r != '0) begin
        dc_r <= PASS_W'(step_r) + PASS_W'(1);
      end
    end
    idx2_r <= oc_q_r;
    if (state_r == S_ELD) begin
      out_val_r  <= val_q_r;
      out_pos_r  <= pos_ext[POS_W-1:0];
      out_pass_r <= pass_r;
      out_last_r <= ((i_r + CNT_W'(1)) == n_r);
    end
  end

  assign out_tdata  = {{PAD_W{1'b0}}, out_pass_r, out_pos_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

endmodule

[hw/rtl/lsdrs_checker.sv]
// Port-level checker for the decimal LSD radix sort block, bound to the top level.
// Depends on lsdrs_pkg and lsd_decimal_radix_sort_unit.
`timescale 1ns / 1ps

module lsdrs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [lsdrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready
);
  import lsdrs_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The block never takes a request while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request accepted while emitting");

  // After a result that is not the last of the list, the pass is still running.
  a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("ready in the middle of a list");

  // After the last result of a list, the block is idle again.
  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("not idle after the end of a list");

endmodule

bind lsd_decimal_radix_sort_unit lsdrs_checker u_lsdrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
